// ===== hw/rtl/flex_pkg.sv =====
package flex_pkg;

   localparam int CharBits = 8;
   localparam int KindBits = 5;
   localparam int LenOutBits = 16;
   localparam int NumWords = 8;
   localparam int MaxWordLen = 9;

   typedef enum logic [KindBits-1:0] {
      K_OP = 5'd0, K_EOL = 5'd1, K_SPACE = 5'd2, K_LPAR = 5'd3, K_RPAR = 5'd4,
      K_LSQ = 5'd5, K_RSQ = 5'd6, K_PTR = 5'd7, K_STR = 5'd8, K_KEY = 5'd9,
      K_IDENT = 5'd10, K_DEC = 5'd11, K_INT = 5'd12, K_COMMA = 5'd13,
      K_SEMI = 5'd14, K_CMT = 5'd15, K_ERR = 5'd16
   } kind_type;

   // one token result as it travels from the scanner to the output queue
   typedef struct packed {
      logic [KindBits-1:0] kind;
      logic [LenOutBits-1:0] len;
      logic group_last;
      logic stream_last;
   } tok_entry_type;

   // reserved words: letter at a given position, and length
   function automatic logic [CharBits-1:0] word_char(input logic [2:0] w,
                                                     input logic [3:0] p);
      logic [8*MaxWordLen-1:0] s;
      logic [CharBits-1:0] r;
      s = '0;
      case (w)
         3'd0: s[8*3-1:0] = "ton";
         3'd1: s[8*3-1:0] = "dna";
         3'd2: s[8*2-1:0] = "ro";
         3'd3: s[8*5-1:0] = "erehw";
         3'd4: s[8*3-1:0] = "iaf";
         3'd5: s[8*6-1:0] = "dneiaf";
         3'd6: s[8*9-1:0] = "snoitcnuf";
         default: s[8*3-1:0] = "fed";
      endcase
      r = '0;
      if (p < 4'(MaxWordLen)) r = s[8*p +: 8];
      return r;
   endfunction

   function automatic logic [3:0] word_len(input logic [2:0] w);
      logic [3:0] r;
      case (w)
         3'd2: r = 4'd2;
         3'd3: r = 4'd5;
         3'd5: r = 4'd6;
         3'd6: r = 4'd9;
         default: r = 4'd3;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/formula_lexer_top.sv =====
// Formula lexer: turns a byte stream of formula text into tokens.
// Input channel req_: one text byte per beat, req_tlast marks the last byte.
// Result channel rsp_: one token per beat (kind, length); rsp_tuser[0] marks
// the last token caused by one input byte, rsp_tlast the final token of text.
// An input byte yields zero to three tokens; a token is emitted once the byte
// that ends it arrives, when its results are written into the token queue.
// Throughput is one byte per cycle while the queue has room: the scanner
// does a full step per cycle and writes its results into an eight-entry
// token queue. The queue drains one token per cycle, so when three results
// pile up input pauses briefly. When the receiver stalls the queue fills and
// req_tready drops once fewer than three free entries remain; nothing is lost.
// An unmatched byte, an unclosed string/comment or a text that ends in ! or -
// gives an error token with length zero and drops bytes up to the end of the text.
// Reset (synchronous) empties the queue and returns the scanner to the
// token-start state; no clearing pass is needed.
module formula_lexer_top import flex_pkg::*; #(
   parameter int LENGTH_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic req_tlast,         // end_of_text
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata,  // [4:0] kind, [20:5] token_length, zero pad
   output logic rsp_tlast,         // stream_last
   output logic rsp_tuser          // group_last
);

   logic [1:0] cnt;
   tok_entry_type r0, r1, r2, q;
   logic space_ok;

   flex_scan #(.LENGTH_BITS(LENGTH_BITS)) u_scan (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_char(req_tdata), .in_eot(req_tlast), .space_ok,
      .res_count(cnt), .res0(r0), .res1(r1), .res2(r2));

   flex_queue u_queue (
      .clock, .reset, .wr_count(cnt), .wr0(r0), .wr1(r1), .wr2(r2),
      .space_ok, .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_tok(q));

   assign rsp_tdata = {3'b000, q.len, q.kind};
   assign rsp_tlast = q.stream_last;
   assign rsp_tuser = q.group_last;

endmodule

// ===== hw/rtl/flex_scan.sv =====
module flex_scan import flex_pkg::*; #(
   parameter int LENGTH_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [CharBits-1:0] in_char,
   input  logic in_eot,
   input  logic space_ok,
   output logic [1:0] res_count,
   output tok_entry_type res0,
   output tok_entry_type res1,
   output tok_entry_type res2
);

   typedef enum logic [3:0] {
      S_IDLE, S_WORD, S_INT, S_INTDOT, S_DEC, S_LT, S_GT, S_BANG, S_MINUS,
      S_DOT, S_STR, S_CMT
   } state_type;

   localparam logic [LENGTH_BITS-1:0] MaxLen = '1;

   state_type state_ff, state_in;
   logic [LENGTH_BITS-1:0] run_ff, run_in, ipart_ff, ipart_in;
   logic [NumWords-1:0] flags_ff, flags_in;
   logic [CharBits-1:0] first_ff, first_in;
   logic drop_ff, drop_in;

   assign in_ready = space_ok;
   wire take = in_valid && in_ready;

   function automatic logic [LenOutBits-1:0] olen(input logic [LENGTH_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[LenOutBits-1:0];
   endfunction

   function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
      return (v == MaxLen) ? v : v + 1'b1;
   endfunction

   // one scan step: up to three results and next state
   always_comb begin
      tok_entry_type r [3];
      logic [1:0] n;
      logic err, again, letter, digit, boundary;
      logic [2:0] pass;
      kind_type wk;
      logic [3:0] rl4;
      logic [CharBits-1:0] c;
      state_in = state_ff; run_in = run_ff; ipart_in = ipart_ff;
      flags_in = flags_ff; first_in = first_ff; drop_in = drop_ff;
      for (int i = 0; i < 3; i++) r[i] = '0;
      n = '0; err = 1'b0; c = in_char;
      again = 1'b0; boundary = 1'b0; pass = '0; wk = K_IDENT; rl4 = '0;
      letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      digit = c >= "0" && c <= "9";
      if (take) begin
         if (drop_ff) begin
            if (in_eot) drop_in = 1'b0;
         end else begin
            again = 1'b1;
            for (pass = 3'd0; pass < 3'd3; pass++) begin
               if (again && !err) begin
                  again = 1'b0;
                  unique case (state_in)
                     S_WORD: begin
                        if (run_in == LENGTH_BITS'(1) && first_in == "d" && !letter) begin
                           r[n] = '{K_OP, 16'd1, 1'b0, 1'b0}; n++;
                           state_in = S_IDLE; again = 1'b1;
                        end else if (letter || c == "_") begin
                           for (int w = 0; w < NumWords; w++)
                              if (!(run_in < LENGTH_BITS'(word_len(3'(w))) &&
                                    word_char(3'(w), 4'(run_in)) == c))
                                 flags_in[w] = 1'b0;
                           run_in = sat_inc(run_in);
                        end else begin
                           wk = K_IDENT;
                           rl4 = (run_in < LENGTH_BITS'(10)) ? 4'(run_in) : 4'd15;
                           boundary = !digit;
                           if (boundary)
                              for (int w = NumWords - 1; w >= 0; w--)
                                 if (flags_in[w] && rl4 == word_len(3'(w)))
                                    wk = (w < 4) ? K_OP : K_KEY;
                           r[n] = '{wk, olen(run_in), 1'b0, 1'b0}; n++;
                           state_in = S_IDLE; again = 1'b1;
                        end
                     end
                     S_INT: begin
                        if (digit) run_in = sat_inc(run_in);
                        else if (c == ".") begin
                           ipart_in = run_in; run_in = sat_inc(run_in);
                           state_in = S_INTDOT;
                        end else begin
                           r[n] = '{K_INT, olen(run_in), 1'b0, 1'b0}; n++;
                           state_in = S_IDLE; again = 1'b1;
                        end
                     end
                     S_INTDOT: begin
                        if (digit) begin
                           run_in = sat_inc(run_in); state_in = S_DEC;
                        end else begin
                           r[n] = '{K_INT, olen(ipart_in), 1'b0, 1'b0}; n++;
                           state_in = S_DOT; again = 1'b1;
                        end
                     end
                     S_DEC: begin
                        if (digit) run_in = sat_inc(run_in);
                        else begin
                           r[n] = '{K_DEC, olen(run_in), 1'b0, 1'b0}; n++;
                           state_in = S_IDLE; again = 1'b1;
                        end
                     end
                     S_LT, S_GT: begin
                        r[n] = '{K_OP, (c == "=") ? 16'd2 : 16'd1, 1'b0, 1'b0}; n++;
                        again = c != "="; state_in = S_IDLE;
                     end
                     S_BANG: begin
                        if (c == "=") begin
                           r[n] = '{K_OP, 16'd2, 1'b0, 1'b0}; n++;
                        end else err = 1'b1;
                        state_in = S_IDLE;
                     end
                     S_MINUS: begin
                        if (c == ">") r[n] = '{K_PTR, 16'd2, 1'b0, 1'b0};
                        else r[n] = '{K_OP, 16'd1, 1'b0, 1'b0};
                        n++; again = c != ">"; state_in = S_IDLE;
                     end
                     S_DOT: begin
                        if (c == "+" || c == "-" || c == "*" || c == "/") begin
                           r[n] = '{K_OP, 16'd2, 1'b0, 1'b0}; again = 1'b0;
                        end else begin
                           r[n] = '{K_OP, 16'd1, 1'b0, 1'b0}; again = 1'b1;
                        end
                        n++; state_in = S_IDLE;
                     end
                     S_STR, S_CMT: begin
                        run_in = sat_inc(run_in);
                        if (state_in == S_STR && c == "'") begin
                           r[n] = '{K_STR, olen(run_in), 1'b0, 1'b0}; n++;
                           state_in = S_IDLE;
                        end else if (state_in == S_CMT && c == "#") begin
                           r[n] = '{K_CMT, olen(run_in), 1'b0, 1'b0}; n++;
                           state_in = S_IDLE;
                        end
                     end
                     default: begin
                        run_in = LENGTH_BITS'(1); state_in = S_IDLE;
                        if (letter || c == "_") begin
                           flags_in = '1; first_in = c;
                           for (int w = 0; w < NumWords; w++)
                              if (word_char(3'(w), 4'd0) != c) flags_in[w] = 1'b0;
                           state_in = S_WORD;
                        end else if (digit) state_in = S_INT;
                        else begin
                           case (c)
                              8'h0a: begin r[n] = '{K_EOL, 16'd1, 1'b0, 1'b0}; n++; end
                              " ", 8'h09, 8'h0d, 8'h0c: begin
                                 r[n] = '{K_SPACE, 16'd1, 1'b0, 1'b0}; n++;
                              end
                              "(": begin r[n] = '{K_LPAR, 16'd1, 1'b0, 1'b0}; n++; end
                              ")": begin r[n] = '{K_RPAR, 16'd1, 1'b0, 1'b0}; n++; end
                              "[": begin r[n] = '{K_LSQ, 16'd1, 1'b0, 1'b0}; n++; end
                              "]": begin r[n] = '{K_RSQ, 16'd1, 1'b0, 1'b0}; n++; end
                              ",": begin r[n] = '{K_COMMA, 16'd1, 1'b0, 1'b0}; n++; end
                              ";": begin r[n] = '{K_SEMI, 16'd1, 1'b0, 1'b0}; n++; end
                              "'": state_in = S_STR;
                              "#": state_in = S_CMT;
                              "<": state_in = S_LT;
                              ">": state_in = S_GT;
                              "!": state_in = S_BANG;
                              "-": state_in = S_MINUS;
                              ".": state_in = S_DOT;
                              "*", "+", "^", "%", "/", "=": begin
                                 r[n] = '{K_OP, 16'd1, 1'b0, 1'b0}; n++;
                              end
                              default: err = 1'b1;
                           endcase
                        end
                     end
                  endcase
               end
            end
            // flush pending token at end of text
            if (in_eot && !err) begin
               unique case (state_in)
                  S_WORD: begin
                     wk = K_IDENT;
                     rl4 = (run_in < LENGTH_BITS'(10)) ? 4'(run_in) : 4'd15;
                     for (int w = NumWords - 1; w >= 0; w--)
                        if (flags_in[w] && rl4 == word_len(3'(w)))
                           wk = (w < 4) ? K_OP : K_KEY;
                     r[n] = '{wk, olen(run_in), 1'b0, 1'b0}; n++;
                  end
                  S_INT: begin r[n] = '{K_INT, olen(run_in), 1'b0, 1'b0}; n++; end
                  S_INTDOT: begin
                     r[n] = '{K_INT, olen(ipart_in), 1'b0, 1'b0}; n++;
                     r[n] = '{K_OP, 16'd1, 1'b0, 1'b0}; n++;
                  end
                  S_DEC: begin r[n] = '{K_DEC, olen(run_in), 1'b0, 1'b0}; n++; end
                  S_LT, S_GT, S_DOT: begin r[n] = '{K_OP, 16'd1, 1'b0, 1'b0}; n++; end
                  S_BANG, S_MINUS, S_STR, S_CMT: err = 1'b1;
                  default: ;
               endcase
            end
            if (err) begin
               r[n] = '{K_ERR, 16'd0, 1'b0, 1'b0}; n++;
               state_in = S_IDLE; drop_in = !in_eot;
            end
            if (n != 2'd0) begin
               r[n-1].group_last = 1'b1;
               r[n-1].stream_last = in_eot || err;
            end
            if (in_eot || err) begin
               state_in = S_IDLE; run_in = '0; flags_in = '0; first_in = '0;
               ipart_in = '0;
            end
         end
      end
      res_count = n; res0 = r[0]; res1 = r[1]; res2 = r[2];
   end

   // hold scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; run_ff <= '0; ipart_ff <= '0; flags_ff <= '0;
         first_ff <= '0; drop_ff <= 1'b0;
      end else begin
         state_ff <= state_in; run_ff <= run_in; ipart_ff <= ipart_in;
         flags_ff <= flags_in; first_ff <= first_in; drop_ff <= drop_in;
      end
   end

endmodule

// ===== hw/rtl/flex_queue.sv =====
module flex_queue import flex_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [1:0] wr_count,
   input  tok_entry_type wr0,
   input  tok_entry_type wr1,
   input  tok_entry_type wr2,
   output logic space_ok,
   output logic out_valid,
   input  logic out_ready,
   output tok_entry_type out_tok
);

   localparam int Depth = 8;
   localparam int PtrBits = 3;

   tok_entry_type mem_ff [Depth];
   logic [PtrBits-1:0] wp_ff, rp_ff;
   logic [PtrBits:0] cnt_ff, cnt_in;
   logic pop;

   assign pop = out_valid && out_ready;
   assign out_valid = cnt_ff != '0;
   assign out_tok = mem_ff[rp_ff];
   // room for a worst-case beat of three results
   assign space_ok = cnt_ff <= (PtrBits+1)'(Depth - 3);
   assign cnt_in = cnt_ff + (PtrBits+1)'(wr_count) - (PtrBits+1)'(pop);

   // write up to three entries, advance pointers
   always_ff @(posedge clock) begin
      if (wr_count > 2'd0) mem_ff[wp_ff] <= wr0;
      if (wr_count > 2'd1) mem_ff[wp_ff + 3'd1] <= wr1;
      if (wr_count > 2'd2) mem_ff[wp_ff + 3'd2] <= wr2;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_ff + PtrBits'(wr_count);
         rp_ff <= rp_ff + PtrBits'(pop);
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/flex_checker.sv =====
module flex_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic rsp_tlast,
   input logic rsp_tuser
);

   // kind never beyond the error code
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:0] <= 5'd16) else $error("bad kind");

   // error tokens carry zero length and end the stream
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4:0] == 5'd16 |-> rsp_tdata[20:5] == 16'd0 && rsp_tlast)
      else $error("bad error token");

   // stream end is also group end
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser) else $error("tlast without group end");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");

   // an empty output only fills after an accepted input beat
   a_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid ##1 rsp_tvalid |-> $past(req_tvalid && req_tready))
      else $error("result without input");

endmodule

bind formula_lexer_top flex_checker u_flex_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tlast, .rsp_tuser);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import flex_pkg::*;

   localparam int Limit = 400000;
   localparam int MaxLen = 65535;

   typedef struct {
      kind_type kind;
      logic [15:0] len;
      logic group_last;
      logic stream_last;
   } token_rec;

   // lexer states of the predictor
   typedef enum int {
      L_IDLE, L_WORD, L_INT, L_INTDOT, L_DEC, L_LT, L_GT, L_BANG, L_MINUS, L_DOT,
      L_STR, L_CMT
   } lex_mode;

   // scoreboard: predicts tokens per accepted byte, checks tokens in order
   class token_board;
      token_rec pending[$];
      token_rec step_out[$];
      int mismatches;
      int checked;
      lex_mode mode;
      int run_len;
      logic [7:0] word_flags;
      logic [7:0] lead_char;
      int int_len;
      bit dropping;
      bit err_seen;

      function new();
         mismatches = 0;
         checked = 0;
         clear_state();
      endfunction

      function void clear_state();
         mode = L_IDLE;
         run_len = 0;
         word_flags = '0;
         lead_char = '0;
         int_len = 0;
         dropping = 0;
      endfunction

      function void push(kind_type k, int n);
         token_rec t;
         if (step_out.size() < 3) begin
            t.kind = k;
            t.len = n[15:0];
            t.group_last = 0;
            t.stream_last = 0;
            step_out.push_back(t);
         end
      endfunction

      function void fail_text();
         push(K_ERR, 0);
         err_seen = 1;
         dropping = 1;
         mode = L_IDLE;
      endfunction

      function void bump();
         if (run_len < MaxLen) run_len++;
      endfunction

      function bit letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      // narrow the set of reserved words that still match the run
      function void extend_word(logic [7:0] c);
         string words[8] = '{"not", "and", "or", "where", "fai", "faiend",
                             "functions", "def"};
         for (int w = 0; w < 8; w++)
            if (word_flags[w])
               if (!(run_len < words[w].len() && words[w][run_len] == c))
                  word_flags[w] = 0;
         bump();
      endfunction

      function void close_word(bit boundary);
         int lens[8] = '{3, 3, 2, 5, 3, 6, 9, 3};
         kind_type k;
         k = K_IDENT;
         if (boundary)
            for (int w = 0; w < 8; w++)
               if (word_flags[w] && run_len == lens[w]) begin
                  k = (w < 4) ? K_OP : K_KEY;
                  break;
               end
         push(k, run_len);
      endfunction

      function void begin_token(logic [7:0] c);
         run_len = 1;
         mode = L_IDLE;
         if (letter(c) || c == "_") begin
            run_len = 0;
            word_flags = 8'hFF;
            lead_char = c;
            extend_word(c);
            mode = L_WORD;
         end else if (digit(c)) begin
            mode = L_INT;
         end else begin
            case (c)
               8'h0A: push(K_EOL, 1);
               " ", 8'h09, 8'h0D, 8'h0C: push(K_SPACE, 1);
               "(": push(K_LPAR, 1);
               ")": push(K_RPAR, 1);
               "[": push(K_LSQ, 1);
               "]": push(K_RSQ, 1);
               ",": push(K_COMMA, 1);
               ";": push(K_SEMI, 1);
               "'": mode = L_STR;
               "#": mode = L_CMT;
               "<": mode = L_LT;
               ">": mode = L_GT;
               "!": mode = L_BANG;
               "-": mode = L_MINUS;
               ".": mode = L_DOT;
               "*", "+", "^", "%", "/", "=": push(K_OP, 1);
               default: fail_text();
            endcase
         end
      endfunction

      // run one byte through the state machine; reprocess when a token ends
      function void scan(logic [7:0] c);
         bit again;
         again = 1;
         while (again && !err_seen) begin
            again = 0;
            case (mode)
               L_WORD: begin
                  if (run_len == 1 && lead_char == "d" && !letter(c)) begin
                     push(K_OP, 1);
                     mode = L_IDLE;
                     again = 1;
                  end else if (letter(c) || c == "_") begin
                     extend_word(c);
                  end else begin
                     close_word(!digit(c));
                     mode = L_IDLE;
                     again = 1;
                  end
               end
               L_INT: begin
                  if (digit(c)) bump();
                  else if (c == ".") begin
                     int_len = run_len;
                     bump();
                     mode = L_INTDOT;
                  end else begin
                     push(K_INT, run_len);
                     mode = L_IDLE;
                     again = 1;
                  end
               end
               L_INTDOT: begin
                  if (digit(c)) begin
                     bump();
                     mode = L_DEC;
                  end else begin
                     push(K_INT, int_len);
                     mode = L_DOT;
                     again = 1;
                  end
               end
               L_DEC: begin
                  if (digit(c)) bump();
                  else begin
                     push(K_DEC, run_len);
                     mode = L_IDLE;
                     again = 1;
                  end
               end
               L_LT, L_GT, L_MINUS: begin
                  if (mode == L_MINUS && c == ">") begin
                     push(K_PTR, 2);
                     mode = L_IDLE;
                  end else if (mode != L_MINUS && c == "=") begin
                     push(K_OP, 2);
                     mode = L_IDLE;
                  end else begin
                     push(K_OP, 1);
                     mode = L_IDLE;
                     again = 1;
                  end
               end
               L_BANG: begin
                  if (c == "=") begin
                     push(K_OP, 2);
                     mode = L_IDLE;
                  end else fail_text();
               end
               L_DOT: begin
                  mode = L_IDLE;
                  if (c == "+" || c == "-" || c == "*" || c == "/") push(K_OP, 2);
                  else begin
                     push(K_OP, 1);
                     again = 1;
                  end
               end
               L_STR, L_CMT: begin
                  bump();
                  if (mode == L_STR && c == "'") begin
                     push(K_STR, run_len);
                     mode = L_IDLE;
                  end else if (mode == L_CMT && c == "#") begin
                     push(K_CMT, run_len);
                     mode = L_IDLE;
                  end
               end
               default: begin_token(c);
            endcase
         end
      endfunction

      // pending token at end of text
      function void flush_text();
         case (mode)
            L_WORD: close_word(1);
            L_INT: push(K_INT, run_len);
            L_INTDOT: begin
               push(K_INT, int_len);
               push(K_OP, 1);
            end
            L_DEC: push(K_DEC, run_len);
            L_LT, L_GT, L_DOT: push(K_OP, 1);
            L_BANG, L_MINUS, L_STR, L_CMT: fail_text();
            default: ;
         endcase
      endfunction

      function void note_byte(logic [7:0] c, bit eot);
         step_out.delete();
         err_seen = 0;
         if (dropping) begin
            if (eot) clear_state();
            return;
         end
         scan(c);
         if (eot && !err_seen) flush_text();
         if (step_out.size() > 0) begin
            step_out[$].group_last = 1;
            if (eot || err_seen) step_out[$].stream_last = 1;
         end
         if (eot) clear_state();
         foreach (step_out[i]) pending.push_back(step_out[i]);
      endfunction

      function void check_token(logic [23:0] data, logic last, logic user);
         token_rec e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected token kind=%0d len=%0d", data[4:0], data[20:5]);
            return;
         end
         e = pending.pop_front();
         if (data[4:0] !== e.kind || data[20:5] !== e.len || data[23:21] !== 3'b0 ||
             user !== e.group_last || last !== e.stream_last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("token %0d: expected kind=%0d len=%0d gl=%0b sl=%0b, got kind=%0d len=%0d gl=%0b sl=%0b pad=%0h",
                        checked, e.kind, e.len, e.group_last, e.stream_last,
                        data[4:0], data[20:5], user, last, data[23:21]);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tlast = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;

   token_board board = new();
   int send_idle_pct = 38;
   int recv_idle_pct = 54;
   int cycles = 0;
   int bytes_sent = 0;
   int texts_sent = 0;

   formula_lexer_top dut (.*);

   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= Limit) begin
         $display("[formula_lexer_top] ERROR");
         $finish;
      end
   end

   // note accepted bytes and check accepted tokens
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) board.check_token(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // receiver stalls at random
   always @(negedge clock)
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);

   // drive one byte, holding valid through the handshake
   task automatic send_byte(logic [7:0] c, bit eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= c;
      req_tlast <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
      texts_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic string pick_piece();
      string pieces[] = '{"not", "and", "or", "where", "fai", "faiend", "functions",
                          "def", "d", "d2", "d(", "notx", "and1", "x_y", "_a", "Zq",
                          "12", "3.5", "7.", "4.x", "0.+", "->", "-", "-1", "<=", "<",
                          ">=", ">", "!=", "=", ".+", ".-", ".*", "./", ".", "*", "+",
                          "^", "%", "/", "'ab'", "'a\nb'", "''", "#c#", "#x\ny#",
                          " ", "\t", "\x0d", "\f", "\n", "(", ")", "[", "]", ",", ";"};
      return pieces[$urandom_range(pieces.size() - 1)];
   endfunction

   // mostly well-formed text, sometimes with a raw random byte
   task automatic random_text();
      string s;
      byte b;
      int n;
      s = "";
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 8) begin
            b = byte'($urandom_range(255));
            s = {s, string'(b)};
         end else s = {s, pick_piece()};
         if ($urandom_range(99) < 40) s = {s, " "};
      end
      if (s.len() > 0 && s[0] == 8'h00) s[0] = "a";
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
      texts_sent++;
   endtask

   initial begin
      string directed[] = '{"not and or where d", "fai faiend functions def",
                            "d+x2 d1 abc_ Q", "0 9.9 12. 5.*", "a->b-c", "<=<>=>!=",
                            "'x\ny' #c\n#", "!a", "-", "'open", "\xff"};
      int start;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      foreach (directed[i]) send_text(directed[i]);
      // single-byte texts with the top data bit clear and set
      send_byte(8'h00, 1);
      send_byte(8'h80, 1);
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 54 : 0;
         recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 38 : 0;
         start = bytes_sent;
         while (bytes_sent < start + 60) random_text();
         drain();
      end
      // long run: identifier near saturation is too slow, use a long comment
      send_text({"#", {40{"z"}}, "#"});
      drain();
      $display("Sent %0d bytes in %0d texts, checked %0d tokens.",
               bytes_sent, texts_sent, board.checked);
      $display("Covered all token kinds, errors, drop-to-end and three idling phases.");
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("[formula_lexer_top] OK");
      end else begin
         $display("%0d mismatches, %0d tokens missing", board.mismatches,
                  board.pending.size());
         $display("[formula_lexer_top] ERROR");
      end
      $finish;
   end
endmodule
